// File: rtl/core/stips_pkg.sv
// Package for the sorted-table insert-position search unit.
// Field widths and the command/status structs shared by the controller and datapath.
// No dependencies.
package stips_pkg;

  // Field widths
  localparam int unsigned IdxW = 10;  // entry_index
  localparam int unsigned ValW = 32;  // item_value and table entries
  localparam int unsigned PosW = 11;  // position, probe bounds
  localparam int unsigned CntW = 11;  // entries_in_use

  // Request codes
  localparam logic ReqWrite  = 1'b0;
  localparam logic ReqSearch = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch key and open the search interval
    logic wr_en;     // write the incoming beat into the table
    logic rd_en;     // issue a table read at the current midpoint
    logic step;      // compare read data and narrow the interval
    logic load_out;  // move the answer into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;  // interval holds no more entries
    logic hit;    // an equal entry was probed
  } dp_status_t;

endpackage

// File: rtl/core/stips_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
module stips_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/stips_ctrl.sv
// Controller for the search unit: sequences table writes, probe reads and compares.
// Depends on stips_pkg for the command and status structs.
module stips_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 req_type_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output stips_pkg::dp_cmd_t   cmd_o,
  input  stips_pkg::dp_status_t status_i
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRead   = 2'd1;
  localparam logic [1:0] StCmp    = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_type_i == stips_pkg::ReqSearch) begin
            cmd_o.start = 1'b1;
            state_d     = StRead;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      StRead: begin
        if (status_i.empty || status_i.hit) begin
          state_d = StFinish;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = StCmp;
        end
      end
      StCmp: begin
        cmd_o.step = 1'b1;
        state_d    = StRead;
      end
      StFinish: begin
        // Hold the answer until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/stips_dp.sv
// Datapath for the search unit: count register, table RAM, probe bounds and output register.
// Depends on stips_pkg and stips_ram.
module stips_dp #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stips_pkg::CntW-1:0]    cfg_data_i,
  input  logic [stips_pkg::IdxW-1:0]    entry_index_i,
  input  logic signed [stips_pkg::ValW-1:0] item_value_i,
  input  stips_pkg::dp_cmd_t            cmd_i,
  output stips_pkg::dp_status_t         status_o,
  output logic [stips_pkg::PosW-1:0]    position_o,
  output logic                          found_o
);

  localparam int unsigned PosW = stips_pkg::PosW;
  localparam int unsigned IdxW = stips_pkg::IdxW;
  localparam int unsigned ValW = stips_pkg::ValW;

  logic [stips_pkg::CntW-1:0] entries_q;
  logic [31:0]                cnt_ext;
  logic [31:0]                cnt_clamp;
  logic [PosW-1:0]            n_clamped;

  logic signed [ValW-1:0]     key_q;
  logic [PosW-1:0]            lo_q, end_q, mid_q;
  logic                       hit_q;
  logic [PosW-1:0]            span;
  logic [PosW-1:0]            mid;
  logic [PosW+AW-1:0]         mid_ext;
  logic [IdxW+AW-1:0]         idx_ext;
  logic                       idx_in_range;
  logic [ValW-1:0]            rdata;
  logic signed [ValW-1:0]     entry;

  logic [PosW-1:0]            position_q;
  logic                       found_q;

  // Entry count register, clamped to the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i) begin
      entries_q <= cfg_data_i;
    end
  end

  assign cnt_ext   = 32'(entries_q);
  assign cnt_clamp = (cnt_ext > 32'(DEPTH)) ? 32'(DEPTH) : cnt_ext;
  assign n_clamped = cnt_clamp[PosW-1:0];

  // Midpoint of the half-open interval [lo, end)
  assign span    = end_q - lo_q - PosW'(1);
  assign mid     = lo_q + (span >> 1);
  assign mid_ext = {{AW{1'b0}}, mid};

  // Drop writes to slots beyond the table
  assign idx_ext      = {{AW{1'b0}}, entry_index_i};
  assign idx_in_range = (32'(entry_index_i) < 32'(DEPTH));

  stips_ram #(
    .WIDTH(ValW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en && idx_in_range),
    .waddr_i(idx_ext[AW-1:0]),
    .wdata_i(item_value_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(mid_ext[AW-1:0]),
    .rdata_o(rdata)
  );

  assign entry = rdata;

  // Search bounds: open on start, narrow on each compare
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= item_value_i;
      lo_q  <= '0;
      end_q <= n_clamped;
      hit_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (key_q == entry) begin
        hit_q <= 1'b1;
        lo_q  <= mid_q;
      end else if (key_q < entry) begin
        end_q <= mid_q;
      end else begin
        lo_q  <= mid_q + PosW'(1);
      end
    end
    if (cmd_i.rd_en) begin
      mid_q <= mid;
    end
  end

  assign status_o.empty = (lo_q >= end_q);
  assign status_o.hit   = hit_q;

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      position_q <= lo_q;
      found_q    <= hit_q;
    end
  end

  assign position_o = position_q;
  assign found_o    = found_q;

endmodule

// File: rtl/core/sorted_table_insert_position_search_unit.sv
// Sorted-table insert-position search unit: top level joining controller and datapath.
// Depends on stips_pkg, stips_ctrl, stips_dp and stips_ram.
//
// Holds a table of DEPTH signed 32-bit entries, assumed sorted ascending, and
// answers lower-bound style binary searches over the first entries_in_use
// entries (clamped to DEPTH). A write beat (req_type 0) stores item_value at
// entry_index and gives no result; slots at or beyond DEPTH are dropped. A
// search beat returns the index of an equal entry with found set, or the
// insertion point with found clear. One beat is in flight at a time: a
// search makes p probes, at most ceil(log2(n+1)) for n entries in use. Each
// probe costs one registered read of the table RAM and one compare. The
// output register lets a new beat be taken while a result still waits. The
// table is not cleared at reset; read only entries that have been written.
// The count register takes a write every cycle and is to be changed only
// while the unit is idle.
module sorted_table_insert_position_search_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [stips_pkg::CntW-1:0]        cfg_data_i,
  // Request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [stips_pkg::IdxW-1:0]        entry_index_i,
  input  logic signed [stips_pkg::ValW-1:0] item_value_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [stips_pkg::PosW-1:0]        position_o,
  output logic                              found_o
);

  stips_pkg::dp_cmd_t    cmd;
  stips_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  stips_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  stips_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .entry_index_i(entry_index_i),
    .item_value_i (item_value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .position_o   (position_o),
    .found_o      (found_o)
  );

endmodule

// File: rtl/core/stips_checker.sv
// Port-level checks for the sorted-table insert-position search unit, with its bind.
// Depends on stips_pkg and the top level sorted_table_insert_position_search_unit.
module stips_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              req_type_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [stips_pkg::PosW-1:0]        position_o,
  input logic                              found_o
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(position_o) && $stable(found_o))
    else $error("result payload changed while stalled");

  // A search beat keeps the unit busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == stips_pkg::ReqSearch) |=> in_stall_o)
    else $error("search did not occupy the unit");

  // A write beat leaves the request channel unstalled on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == stips_pkg::ReqWrite) |=> !in_stall_o)
    else $error("write beat stalled the request channel");

  // A new result appears only after a search has kept the unit busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without a search in progress");

endmodule

bind sorted_table_insert_position_search_unit stips_checker u_stips_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .req_type_i (req_type_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .position_o (position_o),
  .found_o    (found_o)
);
